@@ sv/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared types and constants of the SOF/length/CRC-16 frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfp_pkg;

   // default width of the saturating error totals
   localparam int COUNTER_WIDTH_DEFAULT = 32;
   localparam int TOTAL_W = 32;

   // CRC-16/CCITT-FALSE
   localparam logic [15:0] CRC_START = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'h1021;

   // header layout
   localparam int HDR_BYTES   = 6;
   localparam int HDR_SEQ_POS = 2;
   localparam int HDR_LEN_POS = 4;

   // configuration register reset values
   localparam logic [7:0]  SOF_FIRST_RST   = 8'hAA;
   localparam logic [7:0]  SOF_SECOND_RST  = 8'h55;
   localparam logic [15:0] MAX_LEN_RST     = 16'd256;
   localparam logic [31:0] TIMEOUT_US_RST  = 32'd100000;

   // register indexes
   typedef enum logic [1:0] {
      REG_SOF_FIRST  = 2'd0,
      REG_SOF_SECOND = 2'd1,
      REG_MAX_LEN    = 2'd2,
      REG_TIMEOUT_US = 2'd3
   } reg_index_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_NONE    = 3'd0,
      ST_READY   = 3'd1,
      ST_FORMAT  = 3'd2,
      ST_CRC     = 3'd3,
      ST_TIMEOUT = 3'd4
   } status_type;

   // parse phases
   typedef enum logic [2:0] {
      PH_SOF_A    = 3'd0,
      PH_SOF_B    = 3'd1,
      PH_HEADER   = 3'd2,
      PH_PAYLOAD  = 3'd3,
      PH_CRC_LO   = 3'd4,
      PH_CRC_HI   = 3'd5
   } phase_type;

   // configuration seen by the parser
   typedef struct packed {
      logic [7:0]  sof_first;
      logic [7:0]  sof_second;
      logic [15:0] max_payload_length;
      logic [31:0] timeout_us;
   } cfg_type;

endpackage

@@ sv/cfp_if.sv @@
// ----------------------------------------------------------------------------
// cfp_if
// Valid/ready channels of the frame parser: input words, result words and
// configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfp_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  rx_byte;
   logic [31:0] step_us;

   modport source (output valid, action, rx_byte, step_us, input ready);
   modport sink   (input valid, action, rx_byte, step_us, output ready);
endinterface

interface cfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        payload_valid;
   logic [15:0] payload_pos;
   logic [7:0]  payload_byte;
   logic [7:0]  frame_version;
   logic [7:0]  frame_message_id;
   logic [15:0] frame_sequence;
   logic [15:0] frame_payload_length;
   logic [31:0] format_errors;
   logic [31:0] crc_errors;
   logic [31:0] timeouts;

   modport source (output valid, status, payload_valid, payload_pos, payload_byte,
                   frame_version, frame_message_id, frame_sequence,
                   frame_payload_length, format_errors, crc_errors, timeouts,
                   input ready);
   modport sink   (input valid, status, payload_valid, payload_pos, payload_byte,
                   frame_version, frame_message_id, frame_sequence,
                   frame_payload_length, format_errors, crc_errors, timeouts,
                   output ready);
endinterface

interface cfp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cfp_crc16.sv @@
// ----------------------------------------------------------------------------
// cfp_crc16
// One-byte update of CRC-16/CCITT-FALSE, eight shift steps in combinational logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_crc16 (
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);
   import cfp_pkg::*;

   logic [15:0] crc_v;

   // msb-first polynomial division over the byte
   always_comb begin
      crc_v = crc_in ^ {data_in, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (crc_v[15]) begin
            crc_v = {crc_v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc_v = {crc_v[14:0], 1'b0};
         end
      end
      crc_out = crc_v;
   end

endmodule

@@ sv/cfp_csr.sv @@
// ----------------------------------------------------------------------------
// cfp_csr
// Configuration registers: start-of-frame bytes, length limit and timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_csr (
   input  logic            clock,
   input  logic            reset,
   cfp_csr_if.sink         csr,
   output cfp_pkg::cfg_type cfg
);
   import cfp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (reg_index_type'(csr.index))
            REG_SOF_FIRST:  cfg_in.sof_first          = csr.data[7:0];
            REG_SOF_SECOND: cfg_in.sof_second         = csr.data[7:0];
            REG_MAX_LEN:    cfg_in.max_payload_length = csr.data[15:0];
            REG_TIMEOUT_US: cfg_in.timeout_us         = csr.data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sof_first          <= SOF_FIRST_RST;
         cfg_ff.sof_second         <= SOF_SECOND_RST;
         cfg_ff.max_payload_length <= MAX_LEN_RST;
         cfg_ff.timeout_us         <= TIMEOUT_US_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/cfp_parser.sv @@
// ----------------------------------------------------------------------------
// cfp_parser
// Input register, frame parse state machine with CRC check and timeout,
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfp_parser #(
   parameter int COUNTER_WIDTH = cfp_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cfp_pkg::cfg_type cfg,
   cfp_req_if.sink          req,
   cfp_rsp_if.source        rsp
);
   import cfp_pkg::*;

   // input register
   logic        in_valid_ff;
   logic        in_action_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_elapsed_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [7:0]  hdr_store_ff [HDR_BYTES];
   logic        hdr_wr;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [15:0] pay_cnt_ff, pay_cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  chk_lo_ff, chk_lo_in;
   logic [31:0] idle_ff, idle_in;
   logic [7:0]  held_version_ff, held_version_in;
   logic [7:0]  held_msg_id_ff, held_msg_id_in;
   logic [15:0] held_seq_ff, held_seq_in;
   logic [15:0] held_len_ff, held_len_in;
   logic [COUNTER_WIDTH-1:0] fmt_cnt_ff, fmt_cnt_in;
   logic [COUNTER_WIDTH-1:0] crc_cnt_ff, crc_cnt_in;
   logic [COUNTER_WIDTH-1:0] tmo_cnt_ff, tmo_cnt_in;

   // result register
   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic        pvalid_ff, pvalid_in;
   logic [15:0] pindex_ff, pindex_in;
   logic [7:0]  pbyte_ff, pbyte_in;

   logic        fire;
   logic        req_take;
   logic [15:0] crc_next;
   logic [32:0] idle_sum;
   logic [15:0] hdr_len;
   logic [15:0] pay_cnt_inc;

   // handshake: a word moves on whenever the result register is free
   assign fire     = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req_take = req.valid && req.ready;
   assign req.ready = !in_valid_ff || fire;

   cfp_crc16 u_crc (
      .crc_in  (crc_ff),
      .data_in (in_byte_ff),
      .crc_out (crc_next)
   );

   assign idle_sum    = {1'b0, idle_ff} + {1'b0, in_elapsed_ff};
   assign hdr_len     = {in_byte_ff, hdr_store_ff[HDR_LEN_POS]};
   assign pay_cnt_inc = pay_cnt_ff + 16'd1;

   // next state and result
   always_comb begin
      phase_in        = phase_ff;
      hdr_wr          = 1'b0;
      hdr_cnt_in      = hdr_cnt_ff;
      pay_cnt_in      = pay_cnt_ff;
      crc_in          = crc_ff;
      chk_lo_in       = chk_lo_ff;
      idle_in         = idle_ff;
      held_version_in = held_version_ff;
      held_msg_id_in  = held_msg_id_ff;
      held_seq_in     = held_seq_ff;
      held_len_in     = held_len_ff;
      fmt_cnt_in      = fmt_cnt_ff;
      crc_cnt_in      = crc_cnt_ff;
      tmo_cnt_in      = tmo_cnt_ff;
      status_in       = ST_NONE;
      pvalid_in       = 1'b0;
      pindex_in       = 16'd0;
      pbyte_in        = 8'd0;

      if (in_action_ff) begin
         // time advance counts only while a frame is partial
         if (phase_ff != PH_SOF_A) begin
            if (idle_sum >= {1'b0, cfg.timeout_us}) begin
               if (tmo_cnt_ff != '1) tmo_cnt_in = tmo_cnt_ff + 1'b1;
               phase_in   = PH_SOF_A;
               hdr_cnt_in = 3'd0;
               pay_cnt_in = 16'd0;
               crc_in     = CRC_START;
               chk_lo_in  = 8'd0;
               idle_in    = 32'd0;
               status_in  = ST_TIMEOUT;
            end else begin
               idle_in = idle_sum[31:0];
            end
         end
      end else begin
         if (phase_ff != PH_SOF_A) idle_in = 32'd0;
         unique case (phase_ff)
            PH_SOF_A: begin
               if (in_byte_ff == cfg.sof_first) phase_in = PH_SOF_B;
            end
            PH_SOF_B: begin
               // second sof is checked first, a repeated first sof keeps waiting
               if (in_byte_ff == cfg.sof_second) begin
                  phase_in   = PH_HEADER;
                  hdr_cnt_in = 3'd0;
                  crc_in     = CRC_START;
               end else if (in_byte_ff != cfg.sof_first) begin
                  phase_in = PH_SOF_A;
               end
            end
            PH_HEADER: begin
               hdr_wr     = 1'b1;
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               crc_in     = crc_next;
               if (hdr_cnt_ff == 3'(HDR_BYTES - 1)) begin
                  if (hdr_len > cfg.max_payload_length) begin
                     if (fmt_cnt_ff != '1) fmt_cnt_in = fmt_cnt_ff + 1'b1;
                     phase_in   = PH_SOF_A;
                     hdr_cnt_in = 3'd0;
                     pay_cnt_in = 16'd0;
                     crc_in     = CRC_START;
                     chk_lo_in  = 8'd0;
                     idle_in    = 32'd0;
                     status_in  = ST_FORMAT;
                  end else begin
                     held_version_in = hdr_store_ff[0];
                     held_msg_id_in  = hdr_store_ff[1];
                     held_seq_in     = {hdr_store_ff[HDR_SEQ_POS + 1],
                                        hdr_store_ff[HDR_SEQ_POS]};
                     held_len_in     = hdr_len;
                     pay_cnt_in      = 16'd0;
                     phase_in        = (hdr_len == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pvalid_in  = 1'b1;
               pindex_in  = pay_cnt_ff;
               pbyte_in   = in_byte_ff;
               pay_cnt_in = pay_cnt_inc;
               crc_in     = crc_next;
               if (pay_cnt_inc == held_len_ff) phase_in = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               chk_lo_in = in_byte_ff;
               phase_in  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               if ({in_byte_ff, chk_lo_ff} == crc_ff) begin
                  status_in = ST_READY;
               end else begin
                  if (crc_cnt_ff != '1) crc_cnt_in = crc_cnt_ff + 1'b1;
                  status_in = ST_CRC;
               end
               phase_in   = PH_SOF_A;
               hdr_cnt_in = 3'd0;
               pay_cnt_in = 16'd0;
               crc_in     = CRC_START;
               chk_lo_in  = 8'd0;
               idle_in    = 32'd0;
            end
            default: begin
               // unused phase code drops the frame as a format error
               if (fmt_cnt_ff != '1) fmt_cnt_in = fmt_cnt_ff + 1'b1;
               phase_in   = PH_SOF_A;
               hdr_cnt_in = 3'd0;
               pay_cnt_in = 16'd0;
               crc_in     = CRC_START;
               chk_lo_in  = 8'd0;
               idle_in    = 32'd0;
               status_in  = ST_FORMAT;
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff  <= req.action;
         in_byte_ff    <= req.rx_byte;
         in_elapsed_ff <= req.step_us;
      end
   end

   // header byte store
   always_ff @(posedge clock) begin
      if (fire && hdr_wr) begin
         for (int i = 0; i < HDR_BYTES; i++) begin
            if (hdr_cnt_ff == 3'(i)) hdr_store_ff[i] <= in_byte_ff;
         end
      end
   end

   // parse state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SOF_A;
         hdr_cnt_ff      <= 3'd0;
         pay_cnt_ff      <= 16'd0;
         crc_ff          <= CRC_START;
         chk_lo_ff       <= 8'd0;
         idle_ff         <= 32'd0;
         held_version_ff <= 8'd0;
         held_msg_id_ff  <= 8'd0;
         held_seq_ff     <= 16'd0;
         held_len_ff     <= 16'd0;
         fmt_cnt_ff      <= '0;
         crc_cnt_ff      <= '0;
         tmo_cnt_ff      <= '0;
      end else if (fire) begin
         phase_ff        <= phase_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         pay_cnt_ff      <= pay_cnt_in;
         crc_ff          <= crc_in;
         chk_lo_ff       <= chk_lo_in;
         idle_ff         <= idle_in;
         held_version_ff <= held_version_in;
         held_msg_id_ff  <= held_msg_id_in;
         held_seq_ff     <= held_seq_in;
         held_len_ff     <= held_len_in;
         fmt_cnt_ff      <= fmt_cnt_in;
         crc_cnt_ff      <= crc_cnt_in;
         tmo_cnt_ff      <= tmo_cnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= status_in;
         pvalid_ff <= pvalid_in;
         pindex_ff <= pindex_in;
         pbyte_ff  <= pbyte_in;
      end
   end

   // held header fields and totals change only when the next word is taken
   assign rsp.valid                = rsp_valid_ff;
   assign rsp.status               = status_ff;
   assign rsp.payload_valid        = pvalid_ff;
   assign rsp.payload_pos          = pindex_ff;
   assign rsp.payload_byte         = pbyte_ff;
   assign rsp.frame_version        = held_version_ff;
   assign rsp.frame_message_id     = held_msg_id_ff;
   assign rsp.frame_sequence       = held_seq_ff;
   assign rsp.frame_payload_length = held_len_ff;
   assign rsp.format_errors        = TOTAL_W'(fmt_cnt_ff);
   assign rsp.crc_errors           = TOTAL_W'(crc_cnt_ff);
   assign rsp.timeouts             = TOTAL_W'(tmo_cnt_ff);

endmodule

@@ sv/crc16_frame_parser_with_timeout.sv @@
// ----------------------------------------------------------------------------
// crc16_frame_parser_with_timeout
// Path: a word is taken into the input register and moves to the result register
// when that is free. Throughput: one word per cycle while the result side accepts;
// the byte-wide CRC-16 update and 33-bit timeout compare lie between the two registers.
// Reset: synchronous; registers return to defaults, counters and held header
// fields clear, the parser hunts for the first start-of-frame byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_frame_parser_with_timeout #(
   parameter int COUNTER_WIDTH = cfp_pkg::COUNTER_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   cfp_req_if.sink    req_bus,
   cfp_rsp_if.source  rsp_bus,
   cfp_csr_if.sink    csr_bus
);
   import cfp_pkg::*;

   cfg_type cfg;

   // configuration registers
   cfp_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_bus),
      .cfg   (cfg)
   );

   // frame parser
   cfp_parser #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

endmodule
